[rtl/lbc_pkg.sv]
package lbc_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int IDX_W     = $clog2(NUM_SLOTS);

	localparam int OP_W     = 2;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 32;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 2;
	localparam int REF_W    = 8;

	localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

	localparam logic [OP_W-1:0] OP_GET     = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_PIN     = 2'd2;
	localparam logic [OP_W-1:0] OP_UNPIN   = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_COUNT  = 2'd2;

	typedef enum logic {
		FSM_IDLE,
		FSM_BUSY
	} fsm_t;

endpackage

[rtl/lru_block_buffer_cache_core.sv]
// Channel  Handshake            Payload
// -------  -------------------  -----------------------------------------
// in       in_valid / in_stall  opcode, device, block_number, slot
// out      out_valid/out_stall  slot_out, needs_read, status
//
// An operation is first registered by the accepting edge; once the result register
// is free, a later edge runs the 16-way tag compare and the rank pick, updates
// the slot lanes and loads the result register.
// in_stall is high while an operation is in flight; a held result delays the
// update, and no new request is taken while it waits.
// Reset leaves every slot tagged device 0, block 0, not valid, count zero,
// and ranks equal to the slot index.
module lru_block_buffer_cache_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lbc_pkg::OP_W-1:0]      opcode,
	input  logic [lbc_pkg::DEV_W-1:0]     device,
	input  logic [lbc_pkg::BLK_W-1:0]     block_number,
	input  logic [lbc_pkg::SLOT_W-1:0]    slot,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lbc_pkg::SLOT_W-1:0]    slot_out,
	output logic                          needs_read,
	output logic [lbc_pkg::STATUS_W-1:0]  status
);
	import lbc_pkg::*;

	fsm_t state_q, state_nxt;

	// request registers
	logic [OP_W-1:0]   op_q;
	logic [DEV_W-1:0]  dev_q;
	logic [BLK_W-1:0]  blk_q;
	logic [SLOT_W-1:0] slot_q;

	// slot lanes
	logic [DEV_W-1:0] dev_lane_q  [NUM_SLOTS];
	logic [BLK_W-1:0] blk_lane_q  [NUM_SLOTS];
	logic [REF_W-1:0] refs_lane_q [NUM_SLOTS];
	logic [IDX_W-1:0] rank_lane_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;

	// result register
	logic                out_valid_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic                needs_read_q;
	logic [STATUS_W-1:0] status_q;

	logic in_fire;
	logic out_free;
	logic do_update;

	// lookup
	logic [NUM_SLOTS-1:0] match_v, free_v, hit_by_rank, free_by_rank, hit_pick, vic_pick;
	logic [IDX_W-1:0]     hit_rank, vic_rank, hit_idx, vic_idx, op_idx, upd_idx;
	logic                 hit_found, free_found, slot_ok;

	// update controls
	logic                do_tag, do_inc, do_dec, do_valid, do_mru;
	logic [SLOT_W-1:0]   res_slot;
	logic                res_rd;
	logic [STATUS_W-1:0] res_status;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_fire) state_nxt = FSM_BUSY;
			end
			FSM_BUSY: begin
				if (out_free) state_nxt = FSM_IDLE;
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		do_update = 1'b0;
		case (state_q)
			FSM_IDLE: in_stall = 1'b0;
			FSM_BUSY: do_update = out_free;
			default: begin
				in_stall  = 1'b1;
				do_update = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_nxt;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= opcode;
			dev_q  <= device;
			blk_q  <= block_number;
			slot_q <= slot;
		end
	end

	// Tag compare per lane, then fold the lanes onto ranks: ranks are a
	// permutation, so each rank bit names at most one slot.
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			match_v[i] = (dev_lane_q[i] == dev_q) && (blk_lane_q[i] == blk_q);
			free_v[i]  = (refs_lane_q[i] == '0);
		end
		for (int r = 0; r < NUM_SLOTS; r++) begin
			hit_by_rank[r]  = 1'b0;
			free_by_rank[r] = 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (rank_lane_q[i] == IDX_W'(r)) begin
					hit_by_rank[r]  = hit_by_rank[r] | match_v[i];
					free_by_rank[r] = free_by_rank[r] | free_v[i];
				end
			end
		end
		hit_found  = |match_v;
		free_found = |free_v;

		// most recent match, least recent free slot
		hit_rank = '0;
		for (int r = NUM_SLOTS - 1; r >= 0; r--)
			if (hit_by_rank[r]) hit_rank = IDX_W'(r);
		vic_rank = '0;
		for (int r = 0; r < NUM_SLOTS; r++)
			if (free_by_rank[r]) vic_rank = IDX_W'(r);

		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit_pick[i] = match_v[i] && (rank_lane_q[i] == hit_rank);
			vic_pick[i] = free_v[i] && (rank_lane_q[i] == vic_rank);
		end
		hit_idx = '0;
		vic_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (hit_pick[i]) hit_idx = IDX_W'(i);
			if (vic_pick[i]) vic_idx = IDX_W'(i);
		end
	end

	always_comb begin
		op_idx     = IDX_W'(slot_q);
		slot_ok    = 32'(slot_q) < 32'(NUM_SLOTS);
		upd_idx    = op_idx;
		do_tag     = 1'b0;
		do_inc     = 1'b0;
		do_dec     = 1'b0;
		do_valid   = 1'b0;
		do_mru     = 1'b0;
		res_slot   = slot_q;
		res_rd     = 1'b0;
		res_status = STATUS_OK;
		case (op_q)
			OP_GET: begin
				if (hit_found) begin
					upd_idx  = hit_idx;
					res_slot = SLOT_W'(hit_idx);
					if (refs_lane_q[hit_idx] == REF_MAX) begin
						res_status = STATUS_COUNT;
					end else begin
						do_inc   = 1'b1;
						do_valid = 1'b1;
						res_rd   = !valid_q[hit_idx];
					end
				end else if (free_found) begin
					upd_idx  = vic_idx;
					res_slot = SLOT_W'(vic_idx);
					do_tag   = 1'b1;
					res_rd   = 1'b1;
				end else begin
					res_slot   = '0;
					res_status = STATUS_NOFREE;
				end
			end
			OP_PIN: begin
				if (!slot_ok || refs_lane_q[op_idx] == REF_MAX) res_status = STATUS_COUNT;
				else do_inc = 1'b1;
			end
			OP_RELEASE, OP_UNPIN: begin
				if (!slot_ok || refs_lane_q[op_idx] == '0) begin
					res_status = STATUS_COUNT;
				end else begin
					do_dec = 1'b1;
					// last reference gone: move to the front
					do_mru = (op_q == OP_RELEASE) && (refs_lane_q[op_idx] == REF_W'(1));
				end
			end
			default: res_status = STATUS_COUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				dev_lane_q[i]  <= '0;
				blk_lane_q[i]  <= '0;
				refs_lane_q[i] <= '0;
				rank_lane_q[i] <= IDX_W'(i);
			end
		end else if (do_update) begin
			if (do_tag) begin
				dev_lane_q[upd_idx]  <= dev_q;
				blk_lane_q[upd_idx]  <= blk_q;
				refs_lane_q[upd_idx] <= REF_W'(1);
				valid_q[upd_idx]     <= 1'b1;
			end
			if (do_inc) refs_lane_q[upd_idx] <= refs_lane_q[upd_idx] + REF_W'(1);
			if (do_dec) refs_lane_q[upd_idx] <= refs_lane_q[upd_idx] - REF_W'(1);
			if (do_valid) valid_q[upd_idx] <= 1'b1;
			if (do_mru) begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (rank_lane_q[i] < rank_lane_q[upd_idx])
						rank_lane_q[i] <= rank_lane_q[i] + IDX_W'(1);
				rank_lane_q[upd_idx] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (do_update) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (do_update) begin
			slot_out_q   <= res_slot;
			needs_read_q <= res_rd;
			status_q     <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_out   = slot_out_q;
	assign needs_read = needs_read_q;
	assign status     = status_q;

	// ranks stay a permutation: each rank is held by exactly one slot
	for (genvar r = 0; r < NUM_SLOTS; r++) begin : g_rank_chk
		logic [NUM_SLOTS-1:0] owner;
		for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_own
			assign owner[i] = (rank_lane_q[i] == IDX_W'(r));
		end
		a_rank_perm: assert property (@(posedge clk) disable iff (!arst_n) $onehot(owner))
			else $error("rank %0d not held by exactly one slot", r);
	end

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_BUSY && out_free) |=> (out_valid_q && state_q == FSM_IDLE))
		else $error("update cycle did not load the result register");

	a_nofree_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_NOFREE) |-> (slot_out_q == '0 && !needs_read_q))
		else $error("no-free result carries a slot or read request");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && needs_read_q) |-> (status_q == STATUS_OK))
		else $error("read requested on a failed transaction");

endmodule
